[design/lts_pkg.sv]
// shared types, codes and constants of the line transient supervisor
package lts_pkg;

  localparam int LANES          = 4;
  localparam int SAMPLE_W       = 16;
  localparam int CFG_IDX_W      = 3;
  localparam int CHANNELS_DEF   = 4;
  localparam int UNDEF_MARK_DEF = 65535;

  localparam logic ACTION_TICK = 1'b0;
  localparam logic ACTION_SAVE = 1'b1;

  typedef enum logic [2:0] {
    ST_UNDEF = 3'd0,
    ST_SHORT = 3'd1,
    ST_BREAK = 3'd2,
    ST_OVER  = 3'd3,
    ST_UNDER = 3'd4,
    ST_NORM  = 3'd5
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SETTLE_DEV   = 3'd0,
    REG_SHORT_TH     = 3'd1,
    REG_BREAK_TH     = 3'd2,
    REG_ERROR_MARGIN = 3'd3,
    REG_BLINK_PERIOD = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_BAND,
    PH_SPEED,
    PH_LIMIT,
    PH_REFCHK,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic                action;
    logic [1:0]          channel;
    logic [SAMPLE_W-1:0] sample_now_0;
    logic [SAMPLE_W-1:0] sample_now_1;
    logic [SAMPLE_W-1:0] sample_now_2;
    logic [SAMPLE_W-1:0] sample_now_3;
    logic [SAMPLE_W-1:0] sample_prev_0;
    logic [SAMPLE_W-1:0] sample_prev_1;
    logic [SAMPLE_W-1:0] sample_prev_2;
    logic [SAMPLE_W-1:0] sample_prev_3;
  } item_t;

  typedef struct packed {
    logic [2:0]       held_status_0;
    logic [2:0]       held_status_1;
    logic [2:0]       held_status_2;
    logic [2:0]       held_status_3;
    logic [LANES-1:0] transient_mask;
    logic [LANES-1:0] led_mask;
    logic             save_done;
  } result_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [SAMPLE_W-1:0]  value;
  } cfg_write_t;

  typedef struct packed {
    logic above;
    logic below;
  } win_t;

  typedef struct packed {
    logic action_save;
    logic band_out;
    logic undef;
    logic limit_hit;
    logic out_free;
    logic item_fire;
  } seq_cond_t;

  typedef struct packed {
    phase_t phase;
    logic   ready;
    logic   load_result;
  } seq_ctrl_t;

endpackage

[design/lts_if.sv]
// handshake channels of the line transient supervisor
interface lts_item_if;
  logic          valid;
  logic          ready;
  lts_pkg::item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lts_result_if;
  logic            valid;
  logic            ready;
  lts_pkg::result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lts_cfg_if;
  logic               valid;
  logic               ready;
  lts_pkg::cfg_write_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[design/lts_window.sv]
// shared window comparator: x against base plus and minus a margin, widened signed
module lts_window (
  input  logic [lts_pkg::SAMPLE_W-1:0] x,
  input  logic [lts_pkg::SAMPLE_W-1:0] hi_base,
  input  logic [lts_pkg::SAMPLE_W-1:0] lo_base,
  input  logic [lts_pkg::SAMPLE_W-1:0] margin,
  input  logic                         strict,
  output lts_pkg::win_t                win
);

  logic signed [lts_pkg::SAMPLE_W+1:0] xs;
  logic signed [lts_pkg::SAMPLE_W+1:0] hi;
  logic signed [lts_pkg::SAMPLE_W+1:0] lo;

  always_comb begin
    xs = $signed({2'b00, x});
    hi = $signed({2'b00, hi_base}) + $signed({2'b00, margin});
    lo = $signed({2'b00, lo_base}) - $signed({2'b00, margin});
    win.above = strict ? (xs > hi) : (xs >= hi);
    win.below = strict ? (xs < lo) : (xs <= lo);
  end

endmodule

[design/lts_seq.sv]
// sequencer: walks the channels through band, speed, limit and reference steps; saves skip band and speed
module lts_seq #(
  parameter int ACTIVE = lts_pkg::LANES,
  parameter int IDX_W  = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  lts_pkg::seq_cond_t  cond,
  output lts_pkg::seq_ctrl_t  ctrl,
  output logic [IDX_W-1:0]    idx
);

  lts_pkg::phase_t phase;
  lts_pkg::phase_t phase_next;
  logic [IDX_W-1:0] idx_next;
  logic             last;
  lts_pkg::phase_t  first_step;

  assign last       = (idx == IDX_W'(ACTIVE - 1));
  assign first_step = cond.action_save ? lts_pkg::PH_LIMIT : lts_pkg::PH_BAND;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= lts_pkg::PH_IDLE;
      idx   <= '0;
    end else begin
      phase <= phase_next;
      idx   <= idx_next;
    end
  end

  always_comb begin
    phase_next = phase;
    idx_next   = idx;
    case (phase)
      lts_pkg::PH_IDLE: begin
        idx_next = '0;
        if (cond.item_fire) begin
          phase_next = first_step;
        end
      end
      lts_pkg::PH_BAND: begin
        phase_next = cond.band_out ? lts_pkg::PH_SPEED : lts_pkg::PH_LIMIT;
      end
      lts_pkg::PH_SPEED: begin
        phase_next = lts_pkg::PH_LIMIT;
      end
      lts_pkg::PH_LIMIT: begin
        if (cond.undef || cond.limit_hit) begin
          if (last) begin
            phase_next = lts_pkg::PH_DONE;
          end else begin
            phase_next = first_step;
            idx_next   = idx + 1'b1;
          end
        end else begin
          phase_next = lts_pkg::PH_REFCHK;
        end
      end
      lts_pkg::PH_REFCHK: begin
        if (last) begin
          phase_next = lts_pkg::PH_DONE;
        end else begin
          phase_next = first_step;
          idx_next   = idx + 1'b1;
        end
      end
      lts_pkg::PH_DONE: begin
        if (cond.out_free) begin
          phase_next = lts_pkg::PH_IDLE;
        end
      end
      default: begin
        phase_next = lts_pkg::PH_IDLE;
      end
    endcase
  end

  always_comb begin
    ctrl.phase       = phase;
    ctrl.ready       = (phase == lts_pkg::PH_IDLE);
    ctrl.load_result = (phase == lts_pkg::PH_DONE) && cond.out_free;
  end

endmodule

[design/line_transient_supervisor_core.sv]
// top level of the line transient supervisor
//
// usage
//   item: one tick (action 0) with current and previous sample of each lane,
//     or one save (action 1) of the reference of the given channel.
//   result: one transfer per item with held statuses, transient and led masks
//     and the save flag; cfg: register writes, always ready, idle use only.
// sequencing
//   item.ready is high only while no item is in work. A tick runs each channel
//   through the shared window comparator two to four times (band, speed when
//   out of band, limits, reference when within limits); a save runs it through
//   limits and, when within limits, reference only. The result register is
//   loaded as the sequencer leaves its done state, and the next item is taken
//   once it is back in idle; the shared comparator sets the pace.
// stall
//   the result sits in an output register; the next item is accepted while it
//   waits, and that item is held at its end until the register is taken.
// reset
//   rst clears levels, references, leds, held statuses and the blink counter
//   and restores the register defaults; no result is pending afterwards.
module line_transient_supervisor_core #(
  parameter int              CHANNELS   = lts_pkg::CHANNELS_DEF,
  parameter logic [15:0]     UNDEF_MARK = 16'(lts_pkg::UNDEF_MARK_DEF)
) (
  input  logic           clk,
  input  logic           rst,
  lts_item_if.sink       item,
  lts_result_if.source   result,
  lts_cfg_if.sink        cfg
);

  localparam int ACTIVE = (CHANNELS < lts_pkg::LANES) ? CHANNELS : lts_pkg::LANES;
  localparam int IDX_W  = (ACTIVE > 1) ? $clog2(ACTIVE) : 1;
  localparam int SW     = lts_pkg::SAMPLE_W;

  logic [SW-1:0] settle_deviation;
  logic [SW-1:0] short_threshold;
  logic [SW-1:0] break_threshold;
  logic [SW-1:0] error_margin;
  logic [SW-1:0] blink_period;

  logic [SW-1:0]    steady [ACTIVE];
  logic [SW-1:0]    reference [ACTIVE];
  logic             captured [ACTIVE];
  logic             led [ACTIVE];
  lts_pkg::status_t held [ACTIVE];
  logic [SW-1:0]    blink_count;

  lts_pkg::item_t   item_q;
  logic             save_flag;
  lts_pkg::result_t result_q;
  logic             result_valid;

  lts_pkg::seq_cond_t cond;
  lts_pkg::seq_ctrl_t ctrl;
  logic [IDX_W-1:0]   idx;

  logic [SW-1:0] lane_now [lts_pkg::LANES];
  logic [SW-1:0] lane_prev [lts_pkg::LANES];
  logic [SW-1:0] now_sel;
  logic [SW-1:0] prev_sel;
  logic [SW-1:0] steady_sel;

  logic [SW-1:0] win_x;
  logic [SW-1:0] win_hi;
  logic [SW-1:0] win_lo;
  logic [SW-1:0] win_m;
  logic          win_strict;
  lts_pkg::win_t win;

  logic          item_fire;
  logic          save_ok;
  logic [SW-1:0] blink_inc;
  logic [lts_pkg::LANES-1:0] tmask;
  logic [lts_pkg::LANES-1:0] lmask;
  logic [2:0]    held_lane [lts_pkg::LANES];

  assign item_fire  = item.valid && item.ready;
  assign item.ready = ctrl.ready;
  assign cfg.ready  = 1'b1;
  assign result.valid = result_valid;
  assign result.data  = result_q;

  assign save_ok = ({1'b0, item.data.channel} < 3'(ACTIVE)) &&
                   (steady[item.data.channel[IDX_W-1:0]] != UNDEF_MARK);

  always_comb begin
    lane_now[0]  = item_q.sample_now_0;
    lane_now[1]  = item_q.sample_now_1;
    lane_now[2]  = item_q.sample_now_2;
    lane_now[3]  = item_q.sample_now_3;
    lane_prev[0] = item_q.sample_prev_0;
    lane_prev[1] = item_q.sample_prev_1;
    lane_prev[2] = item_q.sample_prev_2;
    lane_prev[3] = item_q.sample_prev_3;
    now_sel      = lane_now[idx];
    prev_sel     = lane_prev[idx];
    steady_sel   = steady[idx];
  end

  // operand selection for the shared comparator
  always_comb begin
    win_x      = steady_sel;
    win_hi     = reference[idx];
    win_lo     = reference[idx];
    win_m      = error_margin;
    win_strict = 1'b1;
    case (ctrl.phase)
      lts_pkg::PH_BAND: begin
        win_x  = now_sel;
        win_hi = steady_sel;
        win_lo = steady_sel;
        win_m  = settle_deviation;
      end
      lts_pkg::PH_SPEED: begin
        win_x      = now_sel;
        win_hi     = prev_sel;
        win_lo     = prev_sel;
        win_m      = settle_deviation;
        win_strict = idx[0];
      end
      lts_pkg::PH_LIMIT: begin
        win_hi = break_threshold;
        win_lo = short_threshold;
        win_m  = '0;
      end
      default: begin
        win_strict = 1'b1;
      end
    endcase
  end

  lts_window u_window (
    .x       (win_x),
    .hi_base (win_hi),
    .lo_base (win_lo),
    .margin  (win_m),
    .strict  (win_strict),
    .win     (win)
  );

  always_comb begin
    cond.action_save = item_fire ? (item.data.action == lts_pkg::ACTION_SAVE) :
                                   (item_q.action == lts_pkg::ACTION_SAVE);
    cond.band_out    = win.above || win.below;
    cond.undef       = (steady_sel == UNDEF_MARK);
    cond.limit_hit   = win.above || win.below;
    cond.out_free    = !result_valid || result.ready;
    cond.item_fire   = item_fire;
  end

  lts_seq #(
    .ACTIVE (ACTIVE),
    .IDX_W  (IDX_W)
  ) u_seq (
    .clk  (clk),
    .rst  (rst),
    .cond (cond),
    .ctrl (ctrl),
    .idx  (idx)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      settle_deviation <= 16'd100;
      short_threshold  <= 16'd1000;
      break_threshold  <= 16'd20000;
      error_margin     <= 16'd1000;
      blink_period     <= 16'd250;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.data.index)
        lts_pkg::REG_SETTLE_DEV:   settle_deviation <= cfg.data.value;
        lts_pkg::REG_SHORT_TH:     short_threshold  <= cfg.data.value;
        lts_pkg::REG_BREAK_TH:     break_threshold  <= cfg.data.value;
        lts_pkg::REG_ERROR_MARGIN: error_margin     <= cfg.data.value;
        lts_pkg::REG_BLINK_PERIOD: blink_period     <= cfg.data.value;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (item_fire) begin
      item_q <= item.data;
    end
  end

  assign blink_inc = blink_count + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < ACTIVE; c++) begin
        steady[c]    <= '0;
        reference[c] <= '0;
        captured[c]  <= 1'b0;
        led[c]       <= 1'b0;
        held[c]      <= lts_pkg::ST_UNDEF;
      end
      blink_count <= '0;
      save_flag   <= 1'b0;
    end else begin
      if (item_fire) begin
        save_flag <= 1'b0;
        if (item.data.action == lts_pkg::ACTION_SAVE && save_ok) begin
          reference[item.data.channel[IDX_W-1:0]] <= steady[item.data.channel[IDX_W-1:0]];
          save_flag <= 1'b1;
        end
      end
      case (ctrl.phase)
        lts_pkg::PH_BAND: begin
          if (!cond.band_out) begin
            led[idx]    <= 1'b0;
            steady[idx] <= now_sel;
          end
        end
        lts_pkg::PH_SPEED: begin
          if (win.above || win.below) begin
            if (blink_inc > blink_period) begin
              blink_count <= '0;
              steady[idx] <= UNDEF_MARK;
              led[idx]    <= !led[idx];
            end else begin
              blink_count <= blink_inc;
            end
          end else begin
            led[idx]      <= 1'b0;
            steady[idx]   <= now_sel;
            captured[idx] <= 1'b1;
            if (!captured[idx]) begin
              reference[idx] <= now_sel;
            end
          end
        end
        lts_pkg::PH_LIMIT: begin
          if (!cond.undef && cond.limit_hit) begin
            held[idx] <= win.below ? lts_pkg::ST_SHORT : lts_pkg::ST_BREAK;
          end
        end
        lts_pkg::PH_REFCHK: begin
          if (win.above) begin
            held[idx] <= lts_pkg::ST_OVER;
          end else if (win.below) begin
            held[idx] <= lts_pkg::ST_UNDER;
          end else begin
            held[idx] <= lts_pkg::ST_NORM;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int c = 0; c < lts_pkg::LANES; c++) begin
      tmask[c]     = 1'b0;
      lmask[c]     = 1'b0;
      held_lane[c] = 3'(lts_pkg::ST_UNDEF);
    end
    for (int c = 0; c < ACTIVE; c++) begin
      tmask[c]     = (steady[c] == UNDEF_MARK);
      lmask[c]     = led[c];
      held_lane[c] = held[c];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ctrl.load_result) begin
      result_valid <= 1'b1;
    end else if (result.ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_result) begin
      result_q.held_status_0  <= held_lane[0];
      result_q.held_status_1  <= held_lane[1];
      result_q.held_status_2  <= held_lane[2];
      result_q.held_status_3  <= held_lane[3];
      result_q.transient_mask <= tmask;
      result_q.led_mask       <= lmask;
      result_q.save_done      <= save_flag;
    end
  end

endmodule

[design/lts_checker.sv]
// port checker of the line transient supervisor and its bind
module lts_checker (
  input logic             clk,
  input logic             rst,
  input logic             item_valid,
  input logic             item_ready,
  input logic             result_valid,
  input logic             result_ready,
  input lts_pkg::result_t result_data
);

  busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("item accepted while previous item still in work");

  result_held: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result_data))
    else $error("stalled result changed");

  led_needs_transient: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result_data.led_mask & ~result_data.transient_mask) == 4'b0000)
    else $error("led lit on a channel with a defined steady level");

endmodule

bind line_transient_supervisor_core lts_checker u_lts_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item.valid),
  .item_ready   (item.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .result_data  (result.data)
);
